// File: hdl/twlc_pkg.sv
`default_nettype none
package twlc_pkg;

	localparam int ADDR_W           = 7;
	localparam int ADDR_SPAN        = 128;
	localparam int REG_IDX_W        = 3;
	localparam int DATA_W           = 32;
	localparam int MEM_RESET_OFFSET = 5;

	localparam int NUM_SETS_DEF  = 8;
	localparam int MEM_WORDS_DEF = 128;
	localparam int NUM_REGS_DEF  = 8;

	localparam int RECIP_SHIFT = 14;
	localparam int RECIP_ONE   = 1 << RECIP_SHIFT;
	localparam int RECIP_W     = RECIP_SHIFT + 1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK
	} twlc_state_t;

	function automatic logic [ADDR_W-1:0] div_recip(input logic [ADDR_W-1:0] x,
			input logic [RECIP_W-1:0] m);
		logic [ADDR_W+RECIP_W-1:0] p;
		p = {{RECIP_W{1'b0}}, x} * {{ADDR_W{1'b0}}, m};
		return p[RECIP_SHIFT +: ADDR_W];
	endfunction

endpackage
`default_nettype wire

// File: hdl/twlc_req_if.sv
`default_nettype none
interface twlc_req_if;
	import twlc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [ADDR_W-1:0]    word_address;
	logic [REG_IDX_W-1:0] reg_index;
	modport source(output valid, func, word_address, reg_index, input ready);
	modport sink(input valid, func, word_address, reg_index, output ready);
endinterface
`default_nettype wire

// File: hdl/twlc_rsp_if.sv
`default_nettype none
interface twlc_rsp_if;
	import twlc_pkg::*;
	logic              valid;
	logic              ready;
	logic              hit;
	logic              way_used;
	logic              wrote_back;
	logic [DATA_W-1:0] load_data;
	modport source(output valid, hit, way_used, wrote_back, load_data, input ready);
	modport sink(input valid, hit, way_used, wrote_back, load_data, output ready);
endinterface
`default_nettype wire

// File: hdl/twlc_ram.sv
`default_nettype none
module twlc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// File: hdl/two_way_lru_cache_load_store.sv
`default_nettype none
// Channel  Direction  Handshake    Payload
// req      in         valid/ready  func, word_address, reg_index
// rsp      out        valid/ready  hit, way_used, wrote_back, load_data
//
// Each item is taken in ST_IDLE, where its set row and memory word are read from their
// RAMs; in ST_LOOK cache, memory, registers and LRU are updated and the result loaded.
// After reset a clearing pass writes i + 5 into each memory word i; no item is taken
// during it. The result waits in an output register; a new item is taken in ST_IDLE
// while that register is empty or being emptied in the same cycle.
module two_way_lru_cache_load_store #(
	parameter int NUM_SETS  = twlc_pkg::NUM_SETS_DEF,
	parameter int MEM_WORDS = twlc_pkg::MEM_WORDS_DEF,
	parameter int NUM_REGS  = twlc_pkg::NUM_REGS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	twlc_req_if.sink  req,
	twlc_rsp_if.source rsp
);
	import twlc_pkg::*;

	localparam int SET_W   = $clog2(NUM_SETS);
	localparam int TAG_W   = $clog2((ADDR_SPAN - 1) / NUM_SETS + 1);
	localparam int MEM_AW  = $clog2(MEM_WORDS);
	localparam int REG_W   = $clog2(NUM_REGS);
	localparam int WAY_W   = TAG_W + DATA_W;
	localparam int ROW_W   = 2 * WAY_W;
	localparam int SET_REC = (RECIP_ONE + NUM_SETS - 1) / NUM_SETS;
	localparam int MEM_REC = (RECIP_ONE + MEM_WORDS - 1) / MEM_WORDS;
	localparam int REG_REC = (RECIP_ONE + NUM_REGS - 1) / NUM_REGS;

	twlc_state_t state_q, state_d;
	logic [MEM_AW-1:0] clr_q;

	logic              func_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [SET_W-1:0]  set_s1;
	logic [MEM_AW-1:0] mem_idx_s1;
	logic [REG_W-1:0]  reg_s1;

	logic [NUM_SETS-1:0][1:0]     valid_q;
	logic [NUM_SETS-1:0]          lru0_q;
	logic [NUM_REGS-1:0][DATA_W-1:0] regs_q;

	logic              rsp_valid_q;
	logic              hit_q;
	logic              way_q;
	logic              wb_q;
	logic [DATA_W-1:0] ldata_q;

	logic accept;
	logic [ADDR_W-1:0] set_quo, set_rem, mem_quo, mem_rem, reg_ext, reg_quo, reg_rem;

	logic              cache_we;
	logic [ROW_W-1:0]  cache_rdata, new_row;
	logic              mem_we;
	logic [MEM_AW-1:0] mem_waddr;
	logic [DATA_W-1:0] mem_wdata, mem_rdata;

	logic [TAG_W-1:0]  tag0, tag1, vtag;
	logic [DATA_W-1:0] data0, data1, vdata, fill_data, reg_word, load_word, new_data;
	logic v0, v1, hit0, hit1, hit_c, hit_way, need_wb, fill_way, way_c, ld_miss;
	logic [ADDR_W-1:0] vaddr, wb_quo, wb_rem;
	logic [MEM_AW-1:0] wb_idx;

	assign accept  = req.valid && req.ready;
	assign set_quo = div_recip(req.word_address, RECIP_W'(SET_REC));
	assign set_rem = req.word_address - set_quo * ADDR_W'(NUM_SETS);
	assign mem_quo = div_recip(req.word_address, RECIP_W'(MEM_REC));
	assign mem_rem = req.word_address - mem_quo * ADDR_W'(MEM_WORDS);
	assign reg_ext = ADDR_W'(req.reg_index);
	assign reg_quo = div_recip(reg_ext, RECIP_W'(REG_REC));
	assign reg_rem = reg_ext - reg_quo * ADDR_W'(NUM_REGS);

	twlc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_cache_ram (
		.clk   (clk),
		.we    (cache_we),
		.waddr (set_s1),
		.wdata (new_row),
		.raddr (SET_W'(set_rem)),
		.rdata (cache_rdata)
	);

	twlc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_mem_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (MEM_AW'(mem_rem)),
		.rdata (mem_rdata)
	);

	always_comb begin
		tag0     = cache_rdata[DATA_W +: TAG_W];
		data0    = cache_rdata[0 +: DATA_W];
		tag1     = cache_rdata[WAY_W + DATA_W +: TAG_W];
		data1    = cache_rdata[WAY_W +: DATA_W];
		v0       = valid_q[set_s1][0];
		v1       = valid_q[set_s1][1];
		hit0     = v0 && (tag0 == tag_s1);
		hit1     = v1 && (tag1 == tag_s1);
		hit_c    = hit0 || hit1;
		hit_way  = !hit0;
		need_wb  = v0 && v1;
		if (!v0) begin
			fill_way = 1'b0;
		end else if (!v1) begin
			fill_way = 1'b1;
		end else begin
			fill_way = !lru0_q[set_s1];
		end
		way_c    = hit_c ? hit_way : fill_way;
		ld_miss  = !func_s1 && !hit_c;
		vtag     = fill_way ? tag1 : tag0;
		vdata    = fill_way ? data1 : data0;
		vaddr    = ADDR_W'(vtag) * ADDR_W'(NUM_SETS) + ADDR_W'(set_s1);
		wb_quo   = div_recip(vaddr, RECIP_W'(MEM_REC));
		wb_rem   = vaddr - wb_quo * ADDR_W'(MEM_WORDS);
		wb_idx   = MEM_AW'(wb_rem);
		fill_data = (need_wb && (wb_idx == mem_idx_s1)) ? vdata : mem_rdata;
		reg_word  = regs_q[reg_s1];
		load_word = hit_c ? (hit_way ? data1 : data0) : fill_data;
		new_data  = func_s1 ? reg_word : fill_data;
		new_row   = cache_rdata;
		if (way_c) begin
			new_row[WAY_W +: WAY_W] = {tag_s1, new_data};
		end else begin
			new_row[0 +: WAY_W] = {tag_s1, new_data};
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == MEM_AW'(MEM_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		cache_we  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = DATA_W'(clr_q) + DATA_W'(MEM_RESET_OFFSET);
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				req.ready = !rsp_valid_q || rsp.ready;
			end
			ST_LOOK: begin
				cache_we = func_s1 ? hit_c : ld_miss;
				if (ld_miss && need_wb) begin
					mem_we    = 1'b1;
					mem_waddr = wb_idx;
					mem_wdata = vdata;
				end else if (func_s1 && !hit_c) begin
					mem_we    = 1'b1;
					mem_waddr = mem_idx_s1;
					mem_wdata = reg_word;
				end
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			valid_q     <= '0;
			lru0_q      <= '1;
			regs_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_LOOK) begin
				rsp_valid_q <= 1'b1;
				if (ld_miss) begin
					valid_q[set_s1][way_c] <= 1'b1;
				end
				if (!func_s1) begin
					regs_q[reg_s1] <= load_word;
				end
				if (!func_s1 || hit_c) begin
					lru0_q[set_s1] <= way_c;
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1    <= req.func;
			tag_s1     <= TAG_W'(set_quo);
			set_s1     <= SET_W'(set_rem);
			mem_idx_s1 <= MEM_AW'(mem_rem);
			reg_s1     <= REG_W'(reg_rem);
		end
		if (state_q == ST_LOOK) begin
			hit_q   <= hit_c;
			way_q   <= (func_s1 && !hit_c) ? 1'b0 : way_c;
			wb_q    <= ld_miss && need_wb;
			ldata_q <= func_s1 ? '0 : load_word;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.hit        = hit_q;
	assign rsp.way_used   = way_q;
	assign rsp.wrote_back = wb_q;
	assign rsp.load_data  = ldata_q;

	a_accept_to_look: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_LOOK)
		else $error("item accepted but no lookup followed");

	a_result_from_look: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_LOOK))
		else $error("result appeared without a lookup");

	a_wb_only_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && wb_q) |-> !hit_q)
		else $error("write-back reported on a hit");

	a_wb_set_full: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(rsp_valid_q) && wb_q) |-> (valid_q[set_s1] == 2'b11))
		else $error("write-back from a set that is not full");

endmodule
`default_nettype wire
